[hw/rtl/plid_pkg.sv]
// Shared types and constants for the positional list engine.
// No dependencies; used by plid_cell and positional_list_insert_delete_core.
`default_nettype none

package plid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KIND_W       = 3;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;
    localparam int LEN_W        = 7;

    localparam logic signed [VAL_W-1:0] RD_NONE = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ      = 3'd0,
        KIND_INS_HEAD  = 3'd1,
        KIND_INS_TAIL  = 3'd2,
        KIND_INS_AT    = 3'd3,
        KIND_DELETE    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [1:0]              status;
        logic [LEN_W-1:0]        length;
    } rsp_t;

    typedef struct packed {
        logic we;
        logic up;
    } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/positional_list_insert_delete_core.sv]
// Positional list engine top level: command decode, length count, cell row.
// Depends on plid_pkg and plid_cell.
//
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) carries one command per transfer:
//   read, insert at head, insert at tail, insert before a position, delete.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns one result per command:
//   value read (-1 unless a good read), status and the new length.
//   The result is registered and appears in the cycle after the command transfer.
//   Throughput: one command per cycle while cmd_stall is low. Every cell
//   of the row shifts in the same cycle, whatever the position of the edit.
//   The read path is a one-hot select over the cell row.
//   A stall on rsp holds the result register; cmd_stall is raised while a
//   result is held, so no command is taken until it leaves.
//   Reset clears the length and the output valid; entry contents are not
//   cleared and are only read after being written.
//   Inserts into a full list and out-of-range positions change nothing.
`default_nettype none

module positional_list_insert_delete_core #(
    parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cmd_valid,
    output logic             cmd_stall,
    input  wire plid_pkg::cmd_t cmd,
    output logic             rsp_valid,
    input  wire              rsp_stall,
    output plid_pkg::rsp_t   rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    plid_pkg::rsp_t       rsp_reg;
    plid_pkg::rsp_t       rsp_next;

    logic                 accept;
    logic [PW-1:0]        pos_x;
    logic [PW-1:0]        cnt_x;
    logic [PW-1:0]        cnt_next_x;
    logic                 full;
    plid_pkg::cell_ctl_t  ctl;
    logic [AW-1:0]        at;
    logic [AW-1:0]        rd_pos;
    plid_pkg::status_t    st;
    logic signed [plid_pkg::VAL_W-1:0] rd_val;
    logic signed [plid_pkg::VAL_W-1:0] rd_or;

    logic signed [plid_pkg::VAL_W-1:0] entry_w [CAPACITY];
    logic signed [plid_pkg::VAL_W-1:0] tap_w   [CAPACITY];

    assign cmd_stall = rsp_valid_reg & rsp_stall;
    assign accept    = cmd_valid & ~cmd_stall;

    assign pos_x  = PW'(cmd.position);
    assign cnt_x  = PW'(count_reg);
    assign full   = (count_reg == CW'(CAPACITY));
    assign rd_pos = AW'(pos_x);

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or = rd_or | tap_w[i];
        end
    end

    always_comb
    begin
        ctl        = '0;
        at         = '0;
        st         = plid_pkg::ST_DONE;
        rd_val     = plid_pkg::RD_NONE;
        count_next = count_reg;
        unique case (cmd.kind)
            plid_pkg::KIND_READ:
            begin
                if (pos_x < cnt_x)
                begin
                    rd_val = rd_or;
                end
                else
                begin
                    st = plid_pkg::ST_RANGE;
                end
            end
            plid_pkg::KIND_INS_HEAD:
            begin
                if (full)
                begin
                    st = plid_pkg::ST_FULL;
                end
                else
                begin
                    ctl.we     = 1'b1;
                    ctl.up     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            plid_pkg::KIND_INS_TAIL:
            begin
                if (full)
                begin
                    st = plid_pkg::ST_FULL;
                end
                else
                begin
                    ctl.we     = 1'b1;
                    ctl.up     = 1'b1;
                    at         = AW'(cnt_x);
                    count_next = count_reg + 1'b1;
                end
            end
            plid_pkg::KIND_INS_AT:
            begin
                if (pos_x > cnt_x)
                begin
                    st = plid_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    st = plid_pkg::ST_FULL;
                end
                else
                begin
                    ctl.we     = 1'b1;
                    ctl.up     = 1'b1;
                    at         = AW'(pos_x);
                    count_next = count_reg + 1'b1;
                end
            end
            plid_pkg::KIND_DELETE:
            begin
                if (pos_x < cnt_x)
                begin
                    ctl.we     = 1'b1;
                    at         = AW'(pos_x);
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    st = plid_pkg::ST_RANGE;
                end
            end
            default:
            begin
                st = plid_pkg::ST_RANGE;
            end
        endcase
        ctl.we = ctl.we & accept;
    end

    assign cnt_next_x = PW'(count_next);

    always_comb
    begin
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg & rsp_stall;
        if (accept)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.read_value = rd_val;
            rsp_next.status     = st;
            rsp_next.length     = cnt_next_x[plid_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [plid_pkg::VAL_W-1:0] lower_w;
        logic signed [plid_pkg::VAL_W-1:0] upper_w;

        if (g == 0)
        begin : g_first
            assign lower_w = '0;
        end
        else
        begin : g_mid_lo
            assign lower_w = entry_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign upper_w = '0;
        end
        else
        begin : g_mid_hi
            assign upper_w = entry_w[g+1];
        end

        plid_cell #(
            .AW  (AW),
            .IDX (g)
        ) u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .at     (at),
            .rd_pos (rd_pos),
            .value  (cmd.value),
            .lower  (lower_w),
            .upper  (upper_w),
            .entry  (entry_w[g]),
            .tap    (tap_w[g])
        );
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("length count above capacity");

    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (st != plid_pkg::ST_DONE) |=> $stable(count_reg))
        else $error("rejected command changed the length");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (st == plid_pkg::ST_FULL) |-> full)
        else $error("full status while list not full");

    a_bad_read_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status != plid_pkg::ST_DONE)
            |-> (rsp_reg.read_value == plid_pkg::RD_NONE))
        else $error("rejected command returned a read value");
`endif

endmodule

`default_nettype wire

[hw/rtl/plid_cell.sv]
// One storage cell of the list: holds one entry, shifts with its neighbors.
// Depends on plid_pkg.
`default_nettype none

module plid_cell #(
    parameter int AW  = 6,
    parameter int IDX = 0
) (
    input  wire                                  clk,
    input  wire  plid_pkg::cell_ctl_t            ctl,
    input  wire  [AW-1:0]                        at,
    input  wire  [AW-1:0]                        rd_pos,
    input  wire  logic signed [plid_pkg::VAL_W-1:0] value,
    input  wire  logic signed [plid_pkg::VAL_W-1:0] lower,
    input  wire  logic signed [plid_pkg::VAL_W-1:0] upper,
    output logic signed [plid_pkg::VAL_W-1:0]    entry,
    output logic signed [plid_pkg::VAL_W-1:0]    tap
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic signed [plid_pkg::VAL_W-1:0] entry_reg;
    logic signed [plid_pkg::VAL_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.we)
        begin
            if (ctl.up)
            begin
                if (MY_IDX > at)
                begin
                    entry_next = lower;
                end
                else if (MY_IDX == at)
                begin
                    entry_next = value;
                end
            end
            else if (MY_IDX >= at)
            begin
                entry_next = upper;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign tap   = (rd_pos == MY_IDX) ? entry_reg : '0;

endmodule

`default_nettype wire
